### rtl/kmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

	localparam int BYTE_W     = 8;
	localparam int POS_W      = 5;
	localparam int TAB_W      = 4;
	localparam int PAT_IDX_W  = 4;
	localparam int PAT_W      = 128;
	localparam int HALF_W     = 64;
	localparam int START_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              first_of_text;
	} kmp_in_t;

	typedef struct packed {
		logic               match_found;
		logic [START_W-1:0] match_start;
		logic               index_overflow;
	} kmp_out_t;

	// queue entry: byte plus everything the front already worked out
	typedef struct packed {
		logic [BYTE_W-1:0]  text_byte;
		logic               first_of_text;
		logic [START_W-1:0] start;
		logic               ovf;
	} kmp_qent_t;

	typedef struct packed {
		logic [PAT_W-1:0] pattern;
		logic [POS_W-1:0] len;
		logic             rebuild;
	} kmp_cfg_t;

	function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pat,
		input logic [PAT_IDX_W-1:0] idx);
		return pat[{idx, 3'b000} +: BYTE_W];
	endfunction

endpackage

`default_nettype wire

### rtl/kmp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module kmp_front #(
	parameter int INDEX_WIDTH = 32
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  txt_valid,
	input  wire kmp_pkg::kmp_in_t                txt_item,
	output logic                                 txt_stall,
	input  wire logic [kmp_pkg::POS_W-1:0]       len,
	input  wire                                  q_full,
	output logic                                 q_push,
	output kmp_pkg::kmp_qent_t                   q_data
);

	localparam int CUT_W = (INDEX_WIDTH < kmp_pkg::START_W) ? INDEX_WIDTH : kmp_pkg::START_W;

	logic [INDEX_WIDTH-1:0] idx_q;
	logic                   ovf_q;
	logic [INDEX_WIDTH-1:0] cur_idx;
	logic                   cur_ovf;
	logic [INDEX_WIDTH-1:0] diff;

	assign txt_stall = q_full;
	assign q_push    = txt_valid && !q_full;

	always_comb begin
		cur_idx = txt_item.first_of_text ? '0 : idx_q;
		cur_ovf = txt_item.first_of_text ? 1'b0 : ovf_q;
		diff    = cur_idx - INDEX_WIDTH'(len - kmp_pkg::POS_W'(1));
	end

	always_comb begin
		q_data.text_byte     = txt_item.text_byte;
		q_data.first_of_text = txt_item.first_of_text;
		q_data.start         = kmp_pkg::START_W'(diff[CUT_W-1:0]);
		q_data.ovf           = cur_ovf;
	end

	// index saturates at all ones; the overflow flag shows from the next byte on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ovf_q <= 1'b0;
		end else if (q_push) begin
			if (&cur_idx) begin
				idx_q <= cur_idx;
				ovf_q <= 1'b1;
			end else begin
				idx_q <= cur_idx + INDEX_WIDTH'(1);
				ovf_q <= cur_ovf;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/kmp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module kmp_queue (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire kmp_pkg::kmp_qent_t  push_data,
	input  wire                      pop,
	output kmp_pkg::kmp_qent_t       pop_data,
	output logic                     full,
	output logic                     not_empty
);

	kmp_pkg::kmp_qent_t              mem_q [kmp_pkg::QUEUE_DEPTH];
	logic [kmp_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [kmp_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [kmp_pkg::QCNT_W-1:0]      cnt_q;

	assign full      = (cnt_q == kmp_pkg::QCNT_W'(kmp_pkg::QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + kmp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + kmp_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + kmp_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - kmp_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/kmp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module kmp_back #(
	parameter int PATTERN_MAX = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire kmp_pkg::kmp_cfg_t   cfg,
	input  wire                      q_valid,
	input  wire kmp_pkg::kmp_qent_t  q_data,
	output logic                     q_pop,
	output logic                     res_valid,
	input  wire                      res_stall,
	output kmp_pkg::kmp_out_t        res_item
);

	localparam int TAB_AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	localparam logic [1:0] ST_BINIT = 2'd0;
	localparam logic [1:0] ST_BLOOP = 2'd1;
	localparam logic [1:0] ST_IDLE  = 2'd2;
	localparam logic [1:0] ST_STEP  = 2'd3;

	logic [1:0]                     state_q;
	logic [kmp_pkg::TAB_W-1:0]      ft_q [PATTERN_MAX];
	logic [kmp_pkg::POS_W-1:0]      pos_q;
	logic [kmp_pkg::POS_W-1:0]      bi_q;
	logic [kmp_pkg::TAB_W-1:0]      bt_q;
	logic [kmp_pkg::BYTE_W-1:0]     c_q;
	logic [kmp_pkg::START_W-1:0]    start_q;
	logic                           ovf_q;
	logic                           res_valid_q;
	kmp_pkg::kmp_out_t              res_q;

	logic [kmp_pkg::POS_W-1:0]      rd_addr;
	logic [kmp_pkg::TAB_W-1:0]      ft_rd;
	logic [kmp_pkg::BYTE_W-1:0]     pat_i;
	logic [kmp_pkg::BYTE_W-1:0]     pat_t;
	logic [kmp_pkg::BYTE_W-1:0]     pat_p;
	logic                           b_back;
	logic [kmp_pkg::TAB_W-1:0]      b_val;
	logic                           m_back;
	logic [kmp_pkg::POS_W-1:0]      pos_fin;
	logic                           out_free;
	logic                           emit;
	logic [kmp_pkg::POS_W-1:0]      pos_load;

	// one read port on the border table, shared by build and match
	always_comb begin
		if (state_q == ST_BLOOP) begin
			rd_addr = kmp_pkg::POS_W'(bt_q) - kmp_pkg::POS_W'(1);
		end else begin
			rd_addr = pos_q - kmp_pkg::POS_W'(1);
		end
		ft_rd = ft_q[rd_addr[TAB_AW-1:0]];
	end

	always_comb begin
		pat_i  = kmp_pkg::pat_byte(cfg.pattern, bi_q[kmp_pkg::PAT_IDX_W-1:0]);
		pat_t  = kmp_pkg::pat_byte(cfg.pattern, bt_q);
		pat_p  = kmp_pkg::pat_byte(cfg.pattern, pos_q[kmp_pkg::PAT_IDX_W-1:0]);
		b_back = (bt_q != '0) && (pat_i != pat_t);
		b_val  = (pat_i == pat_t) ? bt_q + kmp_pkg::TAB_W'(1) : '0;
		// full match or mismatch on a partial match: fall back one border
		m_back = (pos_q == cfg.len) || ((pos_q != '0) && (pat_p != c_q));
		pos_fin = pos_q + ((pat_p == c_q) ? kmp_pkg::POS_W'(1) : '0);
		out_free = !res_valid_q || !res_stall;
		emit     = (state_q == ST_STEP) && !m_back && out_free;
		q_pop    = (state_q == ST_IDLE) && q_valid && !cfg.rebuild;
		if (q_data.first_of_text || (pos_q > cfg.len)) begin
			pos_load = '0;
		end else begin
			pos_load = pos_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BINIT) begin
			ft_q[0] <= '0;
		end else if (state_q == ST_BLOOP && !b_back) begin
			ft_q[bi_q[TAB_AW-1:0]] <= b_val;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			c_q     <= q_data.text_byte;
			start_q <= q_data.start;
			ovf_q   <= q_data.ovf;
		end
		if (emit) begin
			res_q.match_found    <= (pos_fin == cfg.len);
			res_q.match_start    <= (pos_fin == cfg.len) ? start_q : '0;
			res_q.index_overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BINIT;
			pos_q   <= '0;
			bi_q    <= '0;
			bt_q    <= '0;
		end else if (cfg.rebuild) begin
			state_q <= ST_BINIT;
			pos_q   <= '0;
		end else begin
			case (state_q)
				ST_BINIT: begin
					bi_q <= kmp_pkg::POS_W'(1);
					bt_q <= '0;
					state_q <= (cfg.len == kmp_pkg::POS_W'(1)) ? ST_IDLE : ST_BLOOP;
				end
				ST_BLOOP: begin
					if (b_back) begin
						bt_q <= ft_rd;
					end else begin
						bt_q <= b_val;
						bi_q <= bi_q + kmp_pkg::POS_W'(1);
						if (bi_q + kmp_pkg::POS_W'(1) == cfg.len) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						pos_q   <= pos_load;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (m_back) begin
						pos_q <= kmp_pkg::POS_W'(ft_rd);
					end else if (out_free) begin
						pos_q   <= pos_fin;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_BINIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

`default_nettype wire

### rtl/kmp_pattern_matcher_core.sv
// A byte's result passes through the two-entry queue, the back IDLE and STEP states (STEP
// walks each border fallback) and the output register; a new byte is popped only once the
// last result is registered. Fallbacks total at most one per byte. The back engine rebuilds
// the border table after reset and after every write to a known register; bytes taken
// meanwhile wait in the two-entry queue. Reset (arst_n low, asynchronous): registers to
// length 1 / zero pattern, index, overflow, match position and all handshake state cleared.
`timescale 1ns / 1ps
`default_nettype none

module kmp_pattern_matcher_core #(
	parameter int PATTERN_MAX = 16,
	parameter int INDEX_WIDTH = 32
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	// text channel
	input  wire                                     txt_valid,
	output logic                                    txt_stall,
	input  wire kmp_pkg::kmp_in_t                   txt_item,
	// result channel
	output logic                                    res_valid,
	input  wire                                     res_stall,
	output kmp_pkg::kmp_out_t                       res_item,
	// register writes
	input  wire                                     cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [kmp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [kmp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [kmp_pkg::POS_W-1:0]  len_q;
	logic [kmp_pkg::HALF_W-1:0] pat_lo_q;
	logic [kmp_pkg::HALF_W-1:0] pat_hi_q;
	logic [kmp_pkg::POS_W-1:0]  eff_len;
	logic                       cfg_hit;
	kmp_pkg::kmp_cfg_t          cfg;

	logic                       q_full;
	logic                       q_push;
	kmp_pkg::kmp_qent_t         q_wdata;
	logic                       q_pop;
	kmp_pkg::kmp_qent_t         q_rdata;
	logic                       q_valid;

	// writes are always taken; software must only write while the block is drained (unchecked)
	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index inside {kmp_pkg::REG_LEN, kmp_pkg::REG_PAT_LO,
		kmp_pkg::REG_PAT_HI});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= kmp_pkg::POS_W'(1);
			pat_lo_q <= '0;
			pat_hi_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				kmp_pkg::REG_LEN:    len_q    <= cfg_data[kmp_pkg::POS_W-1:0];
				kmp_pkg::REG_PAT_LO: pat_lo_q <= cfg_data;
				kmp_pkg::REG_PAT_HI: pat_hi_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// length zero acts as one, anything past the table depth as the depth
	always_comb begin
		if (len_q == '0) begin
			eff_len = kmp_pkg::POS_W'(1);
		end else if (len_q > kmp_pkg::POS_W'(PATTERN_MAX)) begin
			eff_len = kmp_pkg::POS_W'(PATTERN_MAX);
		end else begin
			eff_len = len_q;
		end
		cfg.pattern = {pat_hi_q, pat_lo_q};
		cfg.len     = eff_len;
		cfg.rebuild = cfg_hit;
	end

	// front: takes bytes, tracks text index / overflow, precomputes match start
	kmp_front #(
		.INDEX_WIDTH(INDEX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.txt_valid (txt_valid),
		.txt_item  (txt_item),
		.txt_stall (txt_stall),
		.len       (eff_len),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	kmp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.full      (q_full),
		.not_empty (q_valid)
	);

	// back: border table build and the KMP match walk, output register
	kmp_back #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

### rtl/kmp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kmp_checker (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  txt_valid,
	input wire                                  txt_stall,
	input wire kmp_pkg::kmp_in_t                txt_item,
	input wire                                  res_valid,
	input wire                                  res_stall,
	input wire kmp_pkg::kmp_out_t               res_item,
	input wire                                  cfg_valid,
	input wire                                  cfg_ready,
	input wire logic [kmp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input wire logic [kmp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [2:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = txt_valid && !txt_stall;
	assign out_xfer = res_valid && !res_stall;

	// bytes taken but whose result is not yet transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 3'd1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 3'd0)
		else $error("result without a pending byte");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		txt_stall |-> pend_q >= 3'd2)
		else $error("text stalled with queue not full");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.match_found |-> res_item.match_start == '0)
		else $error("match start set without a match");

endmodule

bind kmp_pattern_matcher_core kmp_checker u_kmp_checker (.*);

`default_nettype wire

### tb/sv/tb_kmp_pattern_matcher_core.sv
`timescale 1ns / 1ps

module tb_kmp_pattern_matcher_core;

	import kmp_pkg::*;

	// ------------------------------------------------------------------
	// Run limits
	// ------------------------------------------------------------------
	localparam int unsigned CYCLE_LIMIT = 300000;  // far above the slowest correct run
	localparam int unsigned TEXT_ITEMS  = 1900;    // random text bytes to push through
	localparam int unsigned HOLD_CYCLES = 400;     // long receiver hold-off, fills the block
	localparam int unsigned TAIL_CYCLES = 40;      // quiet time after the last result

	// Index past the end of the register list: the block must ignore it.
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	// ------------------------------------------------------------------
	// Match predictor and store of expected results.
	// Keeps its own copy of the registers, the border table, the match
	// position, the text index and the saturation flag.
	// ------------------------------------------------------------------
	class kmp_match_board;
		logic [4:0]            len_reg;
		logic [127:0]          pattern;
		logic [3:0]            border [16];
		int unsigned           matched;
		logic [31:0]           text_pos;
		bit                    saturated;
		kmp_pkg::kmp_out_t     expected_q [$];
		int                    errors;

		function new();
			len_reg   = 5'd1;
			pattern   = '0;
			matched   = 0;
			text_pos  = '0;
			saturated = 1'b0;
			errors    = 0;
			rebuild_borders();
		endfunction

		// length in use: zero acts as one, anything above 16 as 16
		function int unsigned active_length();
			int unsigned n;
			n = len_reg;
			if (n < 1) n = 1;
			if (n > 16) n = 16;
			return n;
		endfunction

		function logic [7:0] pat_at(int unsigned i);
			return pattern[8*i +: 8];
		endfunction

		// longest proper border of every pattern prefix
		function void rebuild_borders();
			int unsigned n, t;
			n = active_length();
			foreach (border[i]) border[i] = '0;
			for (int unsigned i = 1; i < n; i++) begin
				t = border[i-1];
				while (t > 0 && pat_at(i) != pat_at(t)) t = border[t-1];
				border[i] = (pat_at(i) == pat_at(t)) ? 4'(t + 1) : 4'd0;
			end
		endfunction

		// a register transfer; any known register restarts the match
		function void take_register(logic [kmp_pkg::CFG_IDX_W-1:0] idx,
			logic [kmp_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				kmp_pkg::REG_LEN:    len_reg = data[4:0];
				kmp_pkg::REG_PAT_LO: pattern[63:0] = data;
				kmp_pkg::REG_PAT_HI: pattern[127:64] = data;
				default:             return;
			endcase
			matched = 0;
			rebuild_borders();
		endfunction

		// one text byte in, one expected result out
		function void take_text(kmp_pkg::kmp_in_t it);
			int unsigned       n, pos;
			kmp_pkg::kmp_out_t want;
			n = active_length();
			if (it.first_of_text) begin
				matched   = 0;
				text_pos  = '0;
				saturated = 1'b0;
			end
			pos = matched;
			if (pos > n) pos = 0;
			// fall back along the borders; a full match always falls back first
			while (pos == n || (pos > 0 && pat_at(pos) != it.text_byte))
				pos = border[(pos - 1) & 15];
			if (pat_at(pos) == it.text_byte) pos++;
			want.match_found    = (pos == n);
			want.match_start    = want.match_found ? text_pos - 32'(n - 1) : '0;
			want.index_overflow = saturated;
			expected_q.push_back(want);
			matched = pos;
			// index sticks at its maximum once saturated
			if (&text_pos) saturated = 1'b1;
			else text_pos = text_pos + 1;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= 100)
				$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		endtask

		task check_result(kmp_pkg::kmp_out_t got);
			kmp_pkg::kmp_out_t want;
			if (expected_q.size() == 0) begin
				report("result with nothing expected", got.match_start, '0);
				return;
			end
			want = expected_q.pop_front();
			if (got.match_found !== want.match_found)
				report("match_found", got.match_found, want.match_found);
			if (got.match_start !== want.match_start)
				report("match_start", got.match_start, want.match_start);
			if (got.index_overflow !== want.index_overflow)
				report("index_overflow", got.index_overflow, want.index_overflow);
		endtask
	endclass

	// ------------------------------------------------------------------
	// Clock, reset and block ports; every input known from time zero
	// ------------------------------------------------------------------
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  txt_valid = 1'b0;
	logic                  txt_stall;
	kmp_in_t               txt_item  = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	kmp_out_t              res_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// receiver controls, set by the main sequence
	bit                    no_idle   = 1'b0;  // stretch with no idling on either side
	int unsigned           hold_seq  = 0;     // bump to start one long hold-off
	int unsigned           hold_seen = 0;
	int unsigned           hold_left = 0;
	int unsigned           cycle_cnt = 0;

	kmp_match_board        sb;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	kmp_pattern_matcher_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.txt_valid (txt_valid),
		.txt_stall (txt_stall),
		.txt_item  (txt_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Receiver: random stall with probability about 9 in 100, or a long hold-off
	// counted here so the sender keeps pushing until the input stalls.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 99) < 9) begin
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// result transfers are checked as they happen
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) sb.check_result(res_item);
	end

	// hard stop
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Drivers. write_reg and send_byte leave their valid high after the
	// transfer, so a following transfer keeps it high with a single assignment.
	// ------------------------------------------------------------------

	// one register transfer; the predictor sees it at the accepting edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.take_register(idx, val);
	endtask

	// all three registers in random order, then an optional stray write; length carries junk above bit 4
	task automatic load_pattern(input logic [4:0] len_v, input logic [127:0] pat,
		input bit stray);
		logic [63:0] len_word;
		len_word      = {$urandom(), $urandom()};
		len_word[4:0] = len_v;
		if ($urandom_range(0, 1)) begin
			write_reg(REG_LEN, len_word);
			write_reg(REG_PAT_LO, pat[63:0]);
			write_reg(REG_PAT_HI, pat[127:64]);
		end else begin
			write_reg(REG_PAT_HI, pat[127:64]);
			write_reg(REG_PAT_LO, pat[63:0]);
			write_reg(REG_LEN, len_word);
		end
		if (stray) write_reg(REG_NONE, {$urandom(), $urandom()});
		cfg_valid <= 1'b0;
	endtask

	// one text transfer, with an occasional random idle gap in front of it
	task automatic send_byte(input logic [7:0] b, input bit first);
		kmp_in_t it;
		it.text_byte     = b;
		it.first_of_text = first;
		if (!no_idle && $urandom_range(0, 99) < 9) begin
			txt_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		txt_valid <= 1'b1;
		txt_item  <= it;
		do @(posedge clk); while (txt_stall);
		sb.take_text(it);
	endtask

	// sender pauses until every expected result has come back
	task automatic wait_drained();
		txt_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned sent, p, k, n_eff, items, asz, cut;
		logic [7:0]   alpha [3];
		logic [7:0]   text_q [$];
		logic [127:0] pat;
		logic [4:0]   len_v;

		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// reset setting: one-byte pattern 0x00
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		wait_drained();

		// length zero acts as one; pattern byte 0xFF
		load_pattern(5'd0, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		wait_drained();

		// "abab" over "ababab": overlapping matches
		load_pattern(5'd4, {64'h0, 64'h0000_0000_6261_6261}, 1'b0);
		for (int j = 0; j < 6; j++) send_byte((j % 2) ? 8'h62 : 8'h61, j == 0);
		wait_drained();

		// write mid-text: position restarts, index keeps counting
		write_reg(REG_PAT_HI, 64'h0);
		cfg_valid <= 1'b0;
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h61, 1'b0);
		wait_drained();

		// unknown register index leaves the partial match alone
		write_reg(REG_NONE, {$urandom(), $urandom()});
		cfg_valid <= 1'b0;
		send_byte(8'h62, 1'b0);

		// --- random phases ---
		// each phase: drain, reprogram, then a run of text built mostly from
		// pattern copies (some cut short) and bytes of a small alphabet
		sent = 0;
		p    = 0;
		while (sent < TEXT_ITEMS) begin
			wait_drained();
			case (p)
				0:       len_v = 5'd0;
				1:       len_v = 5'd1;
				2:       len_v = 5'd16;
				3:       len_v = 5'd17;
				4:       len_v = 5'd31;
				default: len_v = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
				                                          : 5'($urandom_range(1, 16));
			endcase
			n_eff = (len_v == 0) ? 1 : (len_v > 16) ? 16 : len_v;

			asz = $urandom_range(1, 3);
			foreach (alpha[i]) alpha[i] = 8'($urandom());
			pat = {$urandom(), $urandom(), $urandom(), $urandom()};
			// most patterns from the alphabet so borders get long; every
			// fourth fully random
			if (p % 4 != 3)
				for (k = 0; k < n_eff; k++) pat[8*k +: 8] = alpha[$urandom_range(0, asz - 1)];
			load_pattern(len_v, pat, p == 2);

			no_idle <= (p == 3);
			if (p == 5) hold_seq <= hold_seq + 1;

			items = $urandom_range(30, 120);
			text_q.delete();
			while (text_q.size() < items) begin
				k = $urandom_range(0, 99);
				if (k < 35) begin
					cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n_eff) : n_eff;
					for (int unsigned j = 0; j < cut; j++) text_q.push_back(pat[8*j +: 8]);
				end else if (k < 90) begin
					text_q.push_back(alpha[$urandom_range(0, asz - 1)]);
				end else begin
					text_q.push_back(8'($urandom()));
				end
			end

			foreach (text_q[j]) begin
				if (p == 7 && j == text_q.size() / 2) wait_drained();
				send_byte(text_q[j], (j == 0) ? ($urandom_range(0, 3) != 0)
				                              : ($urandom_range(0, 99) < 2));
			end
			sent += text_q.size();
			p++;
		end

		// --- wind down ---
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
